/* rtl/counting_semaphore_wait_queue_assert.svh */
// assertion macros for the counting semaphore unit
// clocked on i_clk, disabled while i_rst_n is low; empty when SYNTHESIS is set
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSQ_ASSERT_IMP(lbl, ante, cons, msg)
`define CSQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/csq_pkg.sv */
// shared types, widths and codes of the counting semaphore unit
// no dependencies
`timescale 1ns / 1ps

package csq_pkg;

    localparam int NUM_SEMS_DEF  = 16;
    localparam int NUM_PROCS_DEF = 32;

    localparam int FUNC_W = 2;
    localparam int SID_W  = 4;
    localparam int PID_W  = 5;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_LOCK   = 2'd1,
        FUNC_UNLOCK = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_QUEUE_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CREATE,
        OP_LOCK,
        OP_UNLOCK
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_WAKE
    } t_bk_state;

    typedef struct packed {
        t_op              op;
        logic [SID_W-1:0] sid;
        logic [PID_W-1:0] pid;
        logic [CNT_W-1:0] init;
    } t_cmd;

    typedef struct packed {
        logic [SID_W-1:0] new_sem_id;
        logic             caller_blocked;
        logic             woken_valid;
        logic [PID_W-1:0] woken_pid;
        t_status          status;
    } t_result;

endpackage

/* rtl/csq_front.sv */
// front end: accepts request words, classifies them, holds a two-entry command queue
// depends on csq_pkg
`timescale 1ns / 1ps

module csq_front import csq_pkg::*; #(
    parameter int NUM_SEMS = NUM_SEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SID_W-1:0] i_sem_id,
    input  logic [PID_W-1:0] i_caller_pid,
    input  logic [CNT_W-1:0] i_initial_count,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output t_cmd             o_cmd
);

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       cmd_in;
    logic       in_range;
    logic       push;
    logic       pop;

    // classify
    always_comb begin
        in_range      = (32'(i_sem_id) < NUM_SEMS);
        cmd_in.sid    = i_sem_id;
        cmd_in.pid    = i_caller_pid;
        cmd_in.init   = i_initial_count;
        case (t_func'(i_func))
            FUNC_CREATE: cmd_in.op = OP_CREATE;
            FUNC_LOCK:   cmd_in.op = in_range ? OP_LOCK : OP_NONE;
            FUNC_UNLOCK: cmd_in.op = in_range ? OP_UNLOCK : OP_NONE;
            default:     cmd_in.op = OP_NONE;
        endcase
    end

    assign o_in_ready  = (r_count != 2'(QDEPTH));
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

/* rtl/csq_back.sv */
// back end: semaphore records, wait-queue memory, sequencer and result register
// depends on csq_pkg
`timescale 1ns / 1ps

module csq_back import csq_pkg::*; #(
    parameter int NUM_SEMS  = NUM_SEMS_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    localparam int SEM_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int NF_W  = $clog2(NUM_SEMS + 1);
    localparam int QP_W  = $clog2(NUM_PROCS);
    localparam int OCC_W = $clog2(NUM_PROCS + 1);
    localparam int SUM_W = OCC_W + 1;
    localparam int WS_AW = SEM_W + QP_W;
    localparam int WS_DEPTH = 1 << WS_AW;

    // per-semaphore records
    logic [CNT_W-1:0] r_cnt_mem  [NUM_SEMS];
    logic [QP_W-1:0]  r_head_mem [NUM_SEMS];
    logic [OCC_W-1:0] r_occ_mem  [NUM_SEMS];
    logic [NUM_SEMS-1:0] r_sem_vld;
    // wait-queue storage
    logic [PID_W-1:0] r_ws_mem [WS_DEPTH];
    logic [PID_W-1:0] r_ws_rd;

    t_bk_state        r_state;
    t_bk_state        n_state;
    logic [NF_W-1:0]  r_next_free;
    logic [NF_W-1:0]  n_next_free;
    t_cmd             r_cmd;
    logic [SEM_W-1:0] r_idx;
    logic [CNT_W-1:0] r_rd_count;
    logic [QP_W-1:0]  r_rd_head;
    logic [OCC_W-1:0] r_rd_occ;
    logic             r_rd_vld;
    t_result          r_out;
    logic             r_out_vld;
    t_result          n_res;

    logic [SEM_W-1:0] rd_idx;
    logic             pop;
    logic [QP_W-1:0]  eff_head;
    logic [OCC_W-1:0] eff_occ;
    logic [SUM_W-1:0] tail_sum;
    logic [QP_W-1:0]  tail;
    logic [QP_W-1:0]  head_inc;
    logic             rec_we;
    logic [SEM_W-1:0] rec_idx;
    logic [CNT_W-1:0] rec_count;
    logic [QP_W-1:0]  rec_head;
    logic [OCC_W-1:0] rec_occ;
    logic             ws_we;
    logic             ws_re;
    logic [WS_AW-1:0] ws_addr;
    logic             out_ld;

    assign rd_idx   = SEM_W'(i_cmd.sid);
    assign pop      = i_cmd_valid && o_cmd_ready;
    assign eff_head = r_rd_vld ? r_rd_head : '0;
    assign eff_occ  = r_rd_vld ? r_rd_occ : '0;
    assign tail_sum = SUM_W'(eff_head) + SUM_W'(eff_occ);
    assign tail     = (tail_sum >= SUM_W'(NUM_PROCS)) ? QP_W'(tail_sum - SUM_W'(NUM_PROCS))
                                                      : QP_W'(tail_sum);
    assign head_inc = (eff_head == QP_W'(NUM_PROCS - 1)) ? '0 : eff_head + QP_W'(1);

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        n_next_free = r_next_free;
        rec_we      = 1'b0;
        rec_idx     = r_idx;
        rec_count   = r_rd_count;
        rec_head    = eff_head;
        rec_occ     = eff_occ;
        ws_we       = 1'b0;
        ws_re       = 1'b0;
        ws_addr     = {r_idx, eff_head};
        out_ld      = 1'b0;
        n_res       = '0;
        n_res.status = ST_OK;
        case (r_state)
            BK_IDLE: begin
                o_cmd_ready = !r_out_vld || i_out_ready;
                if (i_cmd_valid && o_cmd_ready) begin
                    case (i_cmd.op)
                        OP_CREATE: begin
                            out_ld = 1'b1;
                            if (32'(r_next_free) < NUM_SEMS) begin
                                rec_we           = 1'b1;
                                rec_idx          = r_next_free[SEM_W-1:0];
                                rec_count        = i_cmd.init;
                                rec_head         = '0;
                                rec_occ          = '0;
                                n_next_free      = r_next_free + NF_W'(1);
                                n_res.new_sem_id = SID_W'(r_next_free);
                            end else begin
                                n_res.status = ST_NO_FREE;
                            end
                        end
                        OP_LOCK, OP_UNLOCK: begin
                            n_state = BK_EXEC;
                        end
                        default: begin
                            out_ld = 1'b1;
                        end
                    endcase
                end
            end
            BK_EXEC: begin
                n_state = BK_IDLE;
                out_ld  = 1'b1;
                rec_we  = 1'b1;
                if (r_cmd.op == OP_LOCK) begin
                    if (r_rd_count != '0) begin
                        rec_count = r_rd_count - CNT_W'(1);
                    end else if (eff_occ == OCC_W'(NUM_PROCS)) begin
                        n_res.status = ST_QUEUE_FULL;
                    end else begin
                        ws_we   = 1'b1;
                        ws_addr = {r_idx, tail};
                        rec_occ = eff_occ + OCC_W'(1);
                        n_res.caller_blocked = 1'b1;
                    end
                end else begin
                    if (eff_occ != '0) begin
                        ws_re    = 1'b1;
                        rec_head = head_inc;
                        rec_occ  = eff_occ - OCC_W'(1);
                        out_ld   = 1'b0;
                        n_state  = BK_WAKE;
                    end else if (r_rd_count != CNT_MAX) begin
                        rec_count = r_rd_count + CNT_W'(1);
                    end
                end
            end
            BK_WAKE: begin
                n_state           = BK_IDLE;
                out_ld            = 1'b1;
                n_res.woken_valid = 1'b1;
                n_res.woken_pid   = r_ws_rd;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_next_free <= '0;
            r_sem_vld   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            if (rec_we) begin
                r_sem_vld[rec_idx] <= 1'b1;
            end
            if (out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_cnt_mem[rec_idx]  <= rec_count;
            r_head_mem[rec_idx] <= rec_head;
            r_occ_mem[rec_idx]  <= rec_occ;
        end
        if (pop) begin
            r_cmd      <= i_cmd;
            r_idx      <= rd_idx;
            r_rd_count <= r_cnt_mem[rd_idx];
            r_rd_head  <= r_head_mem[rd_idx];
            r_rd_occ   <= r_occ_mem[rd_idx];
            r_rd_vld   <= r_sem_vld[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ws_we) begin
            r_ws_mem[ws_addr] <= r_cmd.pid;
        end
        if (ws_re) begin
            r_ws_rd <= r_ws_mem[ws_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

/* rtl/counting_semaphore_wait_queue.sv */
// top level of the counting semaphore unit with per-semaphore fifo wait queues
// depends on csq_pkg, csq_front, csq_back and counting_semaphore_wait_queue_assert.svh
//
//  channel   handshake                  word
//  request   i_in_valid / o_in_ready    i_func, i_sem_id, i_caller_pid, i_initial_count
//  result    o_out_valid / i_out_ready  o_new_sem_id, o_caller_blocked, o_woken_valid,
//                                       o_woken_pid, o_status
//
// a request enters a two-entry command queue; the sequencer answers create or no-op
// from its idle state, lock or unlock from the exec state after the registered record
// read, and a waking unlock from the wake state after the wait-queue memory read
// synchronous active-low reset; per-semaphore valid bits, so no clearing pass
// requests are queued while a result waits on the output register, up to a full queue
`timescale 1ns / 1ps
`include "counting_semaphore_wait_queue_assert.svh"

module counting_semaphore_wait_queue import csq_pkg::*; #(
    parameter int NUM_SEMS  = NUM_SEMS_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SID_W-1:0]  i_sem_id,
    input  logic [PID_W-1:0]  i_caller_pid,
    input  logic [CNT_W-1:0]  i_initial_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SID_W-1:0]  o_new_sem_id,
    output logic              o_caller_blocked,
    output logic              o_woken_valid,
    output logic [PID_W-1:0]  o_woken_pid,
    output logic [STAT_W-1:0] o_status
);

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_ready;
    t_result result;

    csq_front #(
        .NUM_SEMS (NUM_SEMS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_sem_id        (i_sem_id),
        .i_caller_pid    (i_caller_pid),
        .i_initial_count (i_initial_count),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .o_cmd           (cmd)
    );

    csq_back #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_PROCS (NUM_PROCS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_new_sem_id     = result.new_sem_id;
    assign o_caller_blocked = result.caller_blocked;
    assign o_woken_valid    = result.woken_valid;
    assign o_woken_pid      = result.woken_pid;
    assign o_status         = result.status;

    `CSQ_ASSERT_IMP(a_block_wake_excl, o_out_valid, !(o_caller_blocked && o_woken_valid), "blocked and woken in one result")
    `CSQ_ASSERT_IMP(a_event_ok, o_out_valid && (o_caller_blocked || o_woken_valid), o_status == ST_OK, "queue event with error status")
    `CSQ_ASSERT_IMP(a_no_free_clean, o_out_valid && (o_status == ST_NO_FREE), (o_new_sem_id == '0) && !o_caller_blocked && !o_woken_valid, "failed create carries data")
    `CSQ_ASSERT_NXT(a_cmd_pop_busy, cmd_valid && cmd_ready && ((cmd.op == OP_LOCK) || (cmd.op == OP_UNLOCK)), !cmd_ready, "sequencer took a command while busy")

endmodule
